### rtl/core/color_stack_machine_executor_unit_macros.svh
// assertion macros for the colour stack machine executor
`ifndef COLOR_STACK_MACHINE_EXECUTOR_UNIT_MACROS_SVH
`define COLOR_STACK_MACHINE_EXECUTOR_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csm check failed");

// antecedent implies consequent in the next cycle
`define CSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csm check failed");

`endif

### rtl/core/csm_pkg.sv
// shared types, codes and decode function for the colour stack machine executor
package csm_pkg;

   localparam int STACK_DEPTH_DEF = 1024;

   localparam logic [4:0] OP_NONE           = 5'd0;
   localparam logic [4:0] OP_PUSH           = 5'd1;
   localparam logic [4:0] OP_POP            = 5'd2;
   localparam logic [4:0] OP_ADD            = 5'd3;
   localparam logic [4:0] OP_SUB            = 5'd4;
   localparam logic [4:0] OP_MUL            = 5'd5;
   localparam logic [4:0] OP_DIV            = 5'd6;
   localparam logic [4:0] OP_MOD            = 5'd7;
   localparam logic [4:0] OP_NOT            = 5'd8;
   localparam logic [4:0] OP_CMP_GT         = 5'd9;
   localparam logic [4:0] OP_TURN_DIR       = 5'd10;
   localparam logic [4:0] OP_TOGGLE_CHOOSER = 5'd11;
   localparam logic [4:0] OP_DUP            = 5'd12;
   localparam logic [4:0] OP_ROLL           = 5'd13;
   localparam logic [4:0] OP_READ_NUM       = 5'd14;
   localparam logic [4:0] OP_READ_CHAR      = 5'd15;
   localparam logic [4:0] OP_WRITE_NUM      = 5'd16;
   localparam logic [4:0] OP_WRITE_CHAR     = 5'd17;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_NUM  = 2'd1;
   localparam logic [1:0] KIND_CHAR = 2'd2;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_DIV_ZERO  = 2'd3;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;

   function automatic logic [4:0] decode_op(input logic [2:0] fh, input logic [1:0] fl,
                                            input logic [2:0] th, input logic [1:0] tl);
      logic [2:0] fhm;
      logic [2:0] thm;
      logic [1:0] flm;
      logic [1:0] tlm;
      logic [3:0] hd;
      logic [2:0] ld;
      logic [2:0] hs;
      logic [1:0] ls;
      fhm = (fh >= 3'd6) ? fh - 3'd6 : fh;
      thm = (th >= 3'd6) ? th - 3'd6 : th;
      flm = (fl == 2'd3) ? 2'd0 : fl;
      tlm = (tl == 2'd3) ? 2'd0 : tl;
      hd  = {1'b0, thm} + 4'd6 - {1'b0, fhm};
      ld  = {1'b0, tlm} + 3'd3 - {1'b0, flm};
      hs  = (hd >= 4'd6) ? 3'(hd - 4'd6) : hd[2:0];
      ls  = (ld >= 3'd3) ? 2'(ld - 3'd3) : ld[1:0];
      return 5'({2'b0, hs} * 5'd3 + {3'b0, ls});
   endfunction

endpackage

### rtl/core/csm_if.sv
// handshake channels for transition items and result items
interface csm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  from_hue;
   logic [1:0]  from_lightness;
   logic [2:0]  to_hue;
   logic [1:0]  to_lightness;
   logic [23:0] codel_count;
   logic signed [31:0] in_value;

   modport source (output valid, from_hue, from_lightness, to_hue, to_lightness,
                   codel_count, in_value, input ready);
   modport sink (input valid, from_hue, from_lightness, to_hue, to_lightness,
                 codel_count, in_value, output ready);
endinterface

interface csm_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  opcode;
   logic [1:0]  out_kind;
   logic signed [31:0] out_value;
   logic [1:0]  direction;
   logic        chooser_right;
   logic [10:0] depth_now;
   logic [1:0]  status;

   modport source (output valid, opcode, out_kind, out_value, direction, chooser_right,
                   depth_now, status, input ready);
   modport sink (input valid, opcode, out_kind, out_value, direction, chooser_right,
                 depth_now, status, output ready);
endinterface

### rtl/core/csm_divider.sv
// radix-2 restoring unsigned divider, one quotient bit per cycle
module csm_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  csm_pkg::div_req_type div_req,
   output csm_pkg::div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] shifted;
   logic [33:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quo_ff[31]};
      trial   = {1'b0, shifted} - {2'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

### rtl/core/color_stack_machine_executor_unit.sv
// top level of the colour stack machine executor
// Takes one colour transition item at a time, decodes the opcode and runs it on a
// STACK_DEPTH-word stack held in a memory with two registered read ports and one write
// port. Simple operations read the top two entries, execute, then register the result.
// Divide and mod go through a shared one-bit-per-cycle divider. Roll uses the same
// divider for its count and then rotates in place by three reversals, each swapped pair
// read in S_REV_RD and written in S_REV_WA and S_REV_WB; no reversal runs when the count
// comes to nothing. The block accepts no new item until the current result is in the
// output register; that register lets the next item in while the previous result waits.
module color_stack_machine_executor_unit #(
   parameter int STACK_DEPTH = csm_pkg::STACK_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   csm_req_if.sink     req,
   csm_rsp_if.source   rsp
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_DIV, S_REV_RD, S_REV_WA, S_REV_WB, S_FIN
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]  dir_ff, dir_in;
   logic        chooser_ff, chooser_in;
   logic [4:0]  op_ff, op_in;
   logic [23:0] bsize_ff, bsize_in;
   logic [31:0] inval_ff, inval_in;
   logic [1:0]  status_ff, status_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] oval_ff, oval_in;
   logic [CW-1:0] dep_ff, dep_in;
   logic [CW-1:0] base_ff, base_in;
   logic [CW-1:0] rot_ff, rot_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [1:0]  phase_ff, phase_in;
   logic        na_ff, na_in;
   logic        nb_ff, nb_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_op_ff, rsp_op_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_val_ff, rsp_val_in;
   logic [1:0]  rsp_dir_ff, rsp_dir_in;
   logic        rsp_ch_ff, rsp_ch_in;
   logic [10:0] rsp_depth_ff, rsp_depth_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;
   logic        rd_en;
   logic [CW-1:0] ra_addr;
   logic [CW-1:0] rb_addr;
   logic        wr_en;
   logic [CW-1:0] wr_addr;
   logic [31:0] wr_data;

   csm_pkg::div_req_type div_req;
   csm_pkg::div_rsp_type div_rsp;

   logic        accept;
   logic        full;
   logic [CW-1:0] cm1;
   logic [CW-1:0] cm2;
   logic [31:0] prod;
   logic [31:0] qres;
   logic [31:0] rres;
   logic [CW-1:0] rem_n;
   logic [CW-1:0] rot_n;

   csm_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept = req.valid && req.ready;
   assign full   = (count_ff == CW'(STACK_DEPTH));
   assign cm1    = count_ff - CW'(1);
   assign cm2    = count_ff - CW'(2);
   assign prod   = rd_b_ff * rd_a_ff;
   assign qres   = (na_ff ^ nb_ff) ? 32'd0 - div_rsp.quotient : div_rsp.quotient;
   assign rres   = na_ff ? 32'd0 - div_rsp.remainder : div_rsp.remainder;
   assign rem_n  = div_rsp.remainder[CW-1:0];
   assign rot_n  = (nb_ff && rem_n != '0) ? dep_ff - rem_n : rem_n;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dir_in        = dir_ff;
      chooser_in    = chooser_ff;
      op_in         = op_ff;
      bsize_in      = bsize_ff;
      inval_in      = inval_ff;
      status_in     = status_ff;
      kind_in       = kind_ff;
      oval_in       = oval_ff;
      dep_in        = dep_ff;
      base_in       = base_ff;
      rot_in        = rot_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      phase_in      = phase_ff;
      na_in         = na_ff;
      nb_in         = nb_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_op_in     = rsp_op_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      ra_addr       = cm1;
      rb_addr       = cm2;
      wr_en         = 1'b0;
      wr_addr       = cm2;
      wr_data       = '0;
      div_req.start    = 1'b0;
      div_req.dividend = rd_b_ff[31] ? 32'd0 - rd_b_ff : rd_b_ff;
      div_req.divisor  = rd_a_ff[31] ? 32'd0 - rd_a_ff : rd_a_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = csm_pkg::decode_op(req.from_hue, req.from_lightness,
                                              req.to_hue, req.to_lightness);
               bsize_in  = req.codel_count;
               inval_in  = req.in_value;
               status_in = csm_pkg::ST_DONE;
               kind_in   = csm_pkg::KIND_NONE;
               oval_in   = '0;
               rd_en     = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            case (op_ff)
               csm_pkg::OP_PUSH, csm_pkg::OP_READ_NUM, csm_pkg::OP_READ_CHAR: begin
                  if (full) begin
                     status_in = csm_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff;
                     wr_data  = (op_ff == csm_pkg::OP_PUSH) ? {8'd0, bsize_ff} : inval_ff;
                     count_in = count_ff + CW'(1);
                  end
               end
               csm_pkg::OP_POP: begin
                  if (count_ff == '0) status_in = csm_pkg::ST_UNDERFLOW;
                  else count_in = cm1;
               end
               csm_pkg::OP_ADD, csm_pkg::OP_SUB, csm_pkg::OP_MUL, csm_pkg::OP_CMP_GT: begin
                  if (count_ff < CW'(2)) begin
                     status_in = csm_pkg::ST_UNDERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = cm2;
                     count_in = cm1;
                     case (op_ff)
                        csm_pkg::OP_ADD: wr_data = rd_b_ff + rd_a_ff;
                        csm_pkg::OP_SUB: wr_data = rd_b_ff - rd_a_ff;
                        csm_pkg::OP_MUL: wr_data = prod;
                        default: wr_data = {31'd0, $signed(rd_b_ff) > $signed(rd_a_ff)};
                     endcase
                  end
               end
               csm_pkg::OP_DIV, csm_pkg::OP_MOD: begin
                  if (count_ff < CW'(2)) begin
                     status_in = csm_pkg::ST_UNDERFLOW;
                  end else if (rd_a_ff == '0) begin
                     status_in = csm_pkg::ST_DIV_ZERO;
                  end else begin
                     div_req.start = 1'b1;
                     na_in    = rd_b_ff[31];
                     nb_in    = rd_a_ff[31];
                     state_in = S_DIV;
                  end
               end
               csm_pkg::OP_NOT: begin
                  if (count_ff == '0) begin
                     status_in = csm_pkg::ST_UNDERFLOW;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = cm1;
                     wr_data = {31'd0, rd_a_ff == '0};
                  end
               end
               csm_pkg::OP_TURN_DIR: begin
                  if (count_ff == '0) begin
                     status_in = csm_pkg::ST_UNDERFLOW;
                  end else begin
                     dir_in   = dir_ff + rd_a_ff[1:0];
                     count_in = cm1;
                  end
               end
               csm_pkg::OP_TOGGLE_CHOOSER: begin
                  if (count_ff == '0) begin
                     status_in = csm_pkg::ST_UNDERFLOW;
                  end else begin
                     chooser_in = chooser_ff ^ rd_a_ff[0];
                     count_in   = cm1;
                  end
               end
               csm_pkg::OP_DUP: begin
                  if (count_ff == '0) begin
                     status_in = csm_pkg::ST_UNDERFLOW;
                  end else if (full) begin
                     status_in = csm_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff;
                     wr_data  = rd_a_ff;
                     count_in = count_ff + CW'(1);
                  end
               end
               csm_pkg::OP_ROLL: begin
                  if (count_ff < CW'(2)) begin
                     status_in = csm_pkg::ST_UNDERFLOW;
                     count_in  = '0;
                  end else begin
                     count_in = cm2;
                     if (!rd_b_ff[31] && rd_b_ff != '0 && rd_b_ff <= 32'(cm2)) begin
                        dep_in  = rd_b_ff[CW-1:0];
                        base_in = cm2 - rd_b_ff[CW-1:0];
                        nb_in   = rd_a_ff[31];
                        div_req.start    = 1'b1;
                        div_req.dividend = rd_a_ff[31] ? 32'd0 - rd_a_ff : rd_a_ff;
                        div_req.divisor  = rd_b_ff;
                        state_in = S_DIV;
                     end
                  end
               end
               csm_pkg::OP_WRITE_NUM, csm_pkg::OP_WRITE_CHAR: begin
                  if (count_ff == '0) begin
                     status_in = csm_pkg::ST_UNDERFLOW;
                  end else begin
                     count_in = cm1;
                     if (op_ff == csm_pkg::OP_WRITE_NUM) begin
                        kind_in = csm_pkg::KIND_NUM;
                        oval_in = rd_a_ff;
                     end else begin
                        kind_in = csm_pkg::KIND_CHAR;
                        oval_in = {24'd0, rd_a_ff[7:0]};
                     end
                  end
               end
               default: ;
            endcase
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (op_ff == csm_pkg::OP_ROLL) begin
                  if (rot_n == '0) begin
                     state_in = S_FIN;
                  end else begin
                     rot_in   = rot_n;
                     lo_in    = base_ff;
                     hi_in    = base_ff + dep_ff - CW'(1);
                     phase_in = 2'd0;
                     state_in = S_REV_RD;
                  end
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = cm2;
                  wr_data  = (op_ff == csm_pkg::OP_DIV) ? qres : rres;
                  count_in = cm1;
                  state_in = S_FIN;
               end
            end
         end
         S_REV_RD: begin
            ra_addr = lo_ff;
            rb_addr = hi_ff;
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               state_in = S_REV_WA;
            end else begin
               case (phase_ff)
                  2'd0: begin
                     lo_in    = base_ff;
                     hi_in    = base_ff + rot_ff - CW'(1);
                     phase_in = 2'd1;
                  end
                  2'd1: begin
                     lo_in    = base_ff + rot_ff;
                     hi_in    = base_ff + dep_ff - CW'(1);
                     phase_in = 2'd2;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_REV_WA: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff;
            wr_data  = rd_b_ff;
            state_in = S_REV_WB;
         end
         S_REV_WB: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            wr_data  = rd_a_ff;
            lo_in    = lo_ff + CW'(1);
            hi_in    = hi_ff - CW'(1);
            state_in = S_REV_RD;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_op_in     = op_ff;
               rsp_kind_in   = kind_ff;
               rsp_val_in    = oval_ff;
               rsp_dir_in    = dir_ff;
               rsp_ch_in     = chooser_ff;
               rsp_depth_in  = 11'(count_ff);
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dir_ff       <= '0;
         chooser_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dir_ff       <= dir_in;
         chooser_ff   <= chooser_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      bsize_ff      <= bsize_in;
      inval_ff      <= inval_in;
      status_ff     <= status_in;
      kind_ff       <= kind_in;
      oval_ff       <= oval_in;
      dep_ff        <= dep_in;
      base_ff       <= base_in;
      rot_ff        <= rot_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      phase_ff      <= phase_in;
      na_ff         <= na_in;
      nb_ff         <= nb_in;
      rsp_op_ff     <= rsp_op_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   // stack memory, two read ports and one write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
      if (rd_en) begin
         rd_a_ff <= mem[ra_addr[AW-1:0]];
         rd_b_ff <= mem[rb_addr[AW-1:0]];
      end
   end

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.opcode        = rsp_op_ff;
   assign rsp.out_kind      = rsp_kind_ff;
   assign rsp.out_value     = rsp_val_ff;
   assign rsp.direction     = rsp_dir_ff;
   assign rsp.chooser_right = rsp_ch_ff;
   assign rsp.depth_now     = rsp_depth_ff;
   assign rsp.status        = rsp_status_ff;

endmodule

### rtl/core/csm_checker.sv
// port-level checks for the colour stack machine executor, bound to the top level
`include "color_stack_machine_executor_unit_macros.svh"

module csm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_opcode,
   input logic [1:0]  rsp_out_kind,
   input logic [31:0] rsp_out_value,
   input logic [1:0]  rsp_status
);

   logic has_output;
   logic output_ok;
   logic is_char;
   logic is_none;

   assign has_output = rsp_valid && (rsp_out_kind != csm_pkg::KIND_NONE);
   assign output_ok  = (rsp_status == csm_pkg::ST_DONE)
                       && ((rsp_opcode == csm_pkg::OP_WRITE_NUM)
                           || (rsp_opcode == csm_pkg::OP_WRITE_CHAR));
   assign is_char    = rsp_valid && (rsp_out_kind == csm_pkg::KIND_CHAR);
   assign is_none    = rsp_valid && (rsp_out_kind == csm_pkg::KIND_NONE);

   `CSM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `CSM_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CSM_ASSERT_SAME(a_output_done, clock, reset, has_output, output_ok)
   `CSM_ASSERT_SAME(a_char_narrow, clock, reset, is_char, rsp_out_value[31:8] == 24'd0)
   `CSM_ASSERT_SAME(a_none_zero, clock, reset, is_none, rsp_out_value == 32'd0)

endmodule

bind color_stack_machine_executor_unit csm_checker u_csm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_opcode    (rsp.opcode),
   .rsp_out_kind  (rsp.out_kind),
   .rsp_out_value (rsp.out_value),
   .rsp_status    (rsp.status)
);

### tb/sv/color_stack_machine_executor_unit_tb.sv
// self-checking testbench for the colour stack machine executor
`timescale 1ns / 1ps
module color_stack_machine_executor_unit_tb;

   localparam int DEPTH = csm_pkg::STACK_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 30000000;

   typedef struct {
      logic [2:0]  fh;
      logic [1:0]  fl;
      logic [2:0]  th;
      logic [1:0]  tl;
      logic [23:0] bsize;
      logic [31:0] inval;
   } transition_type;

   typedef struct {
      logic [4:0]  opcode;
      logic [1:0]  kind;
      logic [31:0] value;
      logic [1:0]  dir;
      logic        chooser;
      logic [10:0] depth;
      logic [1:0]  status;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csm_req_if req ();
   csm_rsp_if rsp ();

   color_stack_machine_executor_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #5 clock = ~clock;

   transition_type pending_items[$];
   outcome_type    expected_outcomes[$];

   logic [31:0] model_stack[DEPTH];
   int          model_count;
   logic [1:0]  model_dir;
   logic        model_chooser;

   int  mismatches = 0;
   int  cycles = 0;
   int  gap_left = 0;
   int  rsp_gap_left = 0;
   int  stall_left = 0;
   int  hold_request = 0;
   int  drain_request = 0;
   int  accepted = 0;

   // colour pair for an opcode, built from target hue/lightness steps
   function automatic transition_type make_op(logic [4:0] op, logic [23:0] bsize,
                                              logic [31:0] inval);
      transition_type t;
      int fh;
      int fl;
      fh = $urandom_range(0, 7);
      fl = $urandom_range(0, 3);
      t.fh = 3'(fh);
      t.fl = 2'(fl);
      t.th = 3'(((fh % 6) + op / 3) % 6 + (($urandom_range(0, 1) && ((fh % 6) + op / 3) % 6 < 2)
             ? 6 : 0));
      t.tl = 2'(((fl == 3 ? 0 : fl) + op % 3) % 3);
      if (t.tl == 2'd0 && $urandom_range(0, 3) == 0) t.tl = 2'd3;
      t.bsize = bsize;
      t.inval = inval;
      return t;
   endfunction

   function automatic logic [31:0] trunc_div(logic [31:0] b, logic [31:0] a, bit want_rem);
      logic [31:0] mb;
      logic [31:0] ma;
      logic [31:0] q;
      logic [31:0] r;
      mb = b[31] ? -b : b;
      ma = a[31] ? -a : a;
      q = mb / ma;
      r = mb % ma;
      if (want_rem) return b[31] ? -r : r;
      return (b[31] != a[31]) ? -q : q;
   endfunction

   function automatic void execute_transition(transition_type t);
      outcome_type o;
      int hf, ht, lf, lt;
      logic [31:0] a, b, cnt, dep;
      longint sc, m;
      logic [31:0] tmp[DEPTH];
      int base, d;
      hf = t.fh >= 6 ? t.fh - 6 : t.fh;
      ht = t.th >= 6 ? t.th - 6 : t.th;
      lf = t.fl == 3 ? 0 : t.fl;
      lt = t.tl == 3 ? 0 : t.tl;
      o.opcode = 5'(((ht + 6 - hf) % 6) * 3 + (lt + 3 - lf) % 3);
      o.kind = csm_pkg::KIND_NONE;
      o.value = '0;
      o.status = csm_pkg::ST_DONE;
      case (o.opcode)
         csm_pkg::OP_PUSH, csm_pkg::OP_READ_NUM, csm_pkg::OP_READ_CHAR: begin
            if (model_count >= DEPTH) o.status = csm_pkg::ST_FULL;
            else begin
               model_stack[model_count] = (o.opcode == csm_pkg::OP_PUSH) ? {8'd0, t.bsize}
                                                                         : t.inval;
               model_count++;
            end
         end
         csm_pkg::OP_POP: begin
            if (model_count < 1) o.status = csm_pkg::ST_UNDERFLOW;
            else model_count--;
         end
         csm_pkg::OP_ADD, csm_pkg::OP_SUB, csm_pkg::OP_MUL, csm_pkg::OP_DIV, csm_pkg::OP_MOD,
         csm_pkg::OP_CMP_GT: begin
            if (model_count < 2) o.status = csm_pkg::ST_UNDERFLOW;
            else begin
               a = model_stack[model_count - 1];
               b = model_stack[model_count - 2];
               if ((o.opcode == csm_pkg::OP_DIV || o.opcode == csm_pkg::OP_MOD) && a == 0)
                  o.status = csm_pkg::ST_DIV_ZERO;
               else begin
                  model_count -= 2;
                  case (o.opcode)
                     csm_pkg::OP_ADD: model_stack[model_count] = b + a;
                     csm_pkg::OP_SUB: model_stack[model_count] = b - a;
                     csm_pkg::OP_MUL: model_stack[model_count] = b * a;
                     csm_pkg::OP_DIV: model_stack[model_count] = trunc_div(b, a, 0);
                     csm_pkg::OP_MOD: model_stack[model_count] = trunc_div(b, a, 1);
                     default: model_stack[model_count] = ($signed(b) > $signed(a)) ? 1 : 0;
                  endcase
                  model_count++;
               end
            end
         end
         csm_pkg::OP_NOT: begin
            if (model_count < 1) o.status = csm_pkg::ST_UNDERFLOW;
            else model_stack[model_count - 1] = (model_stack[model_count - 1] == 0) ? 1 : 0;
         end
         csm_pkg::OP_TURN_DIR, csm_pkg::OP_TOGGLE_CHOOSER, csm_pkg::OP_WRITE_NUM,
         csm_pkg::OP_WRITE_CHAR: begin
            if (model_count < 1) o.status = csm_pkg::ST_UNDERFLOW;
            else begin
               model_count--;
               a = model_stack[model_count];
               if (o.opcode == csm_pkg::OP_TURN_DIR) model_dir = model_dir + a[1:0];
               else if (o.opcode == csm_pkg::OP_TOGGLE_CHOOSER) model_chooser ^= a[0];
               else if (o.opcode == csm_pkg::OP_WRITE_NUM) begin
                  o.kind = csm_pkg::KIND_NUM;
                  o.value = a;
               end else begin
                  o.kind = csm_pkg::KIND_CHAR;
                  o.value = {24'd0, a[7:0]};
               end
            end
         end
         csm_pkg::OP_DUP: begin
            if (model_count < 1) o.status = csm_pkg::ST_UNDERFLOW;
            else if (model_count >= DEPTH) o.status = csm_pkg::ST_FULL;
            else begin
               model_stack[model_count] = model_stack[model_count - 1];
               model_count++;
            end
         end
         csm_pkg::OP_ROLL: begin
            if (model_count < 2) begin
               model_count = 0;
               o.status = csm_pkg::ST_UNDERFLOW;
            end else begin
               cnt = model_stack[model_count - 1];
               dep = model_stack[model_count - 2];
               model_count -= 2;
               if (!dep[31] && dep != 0 && dep <= model_count) begin
                  sc = longint'($signed(cnt));
                  m = sc % longint'(dep);
                  if (m < 0) m += longint'(dep);
                  if (m != 0) begin
                     base = model_count - int'(dep);
                     for (int i = 0; i < int'(dep); i++) begin
                        d = (i + int'(m)) % int'(dep);
                        tmp[d] = model_stack[base + i];
                     end
                     for (int i = 0; i < int'(dep); i++) model_stack[base + i] = tmp[i];
                  end
               end
            end
         end
         default: ;
      endcase
      o.dir = model_dir;
      o.chooser = model_chooser;
      o.depth = 11'(model_count);
      expected_outcomes.push_back(o);
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'(int'($urandom_range(0, 20)) - 10);
         default: return $urandom();
      endcase
   endfunction

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            execute_transition(pending_items.pop_front());
            accepted++;
            gap_left = random_gap();
         end
         if (drain_request > 0 && pending_items.size() == drain_request
             && expected_outcomes.size() != 0) begin
            req.valid <= 1'b0;
         end else if (gap_left > 0 && !(req.valid && !req.ready)) begin
            gap_left--;
            req.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            if (drain_request > 0 && pending_items.size() == drain_request) drain_request = 0;
            req.valid <= 1'b1;
            req.from_hue <= pending_items[0].fh;
            req.from_lightness <= pending_items[0].fl;
            req.to_hue <= pending_items[0].th;
            req.to_lightness <= pending_items[0].tl;
            req.codel_count <= pending_items[0].bsize;
            req.in_value <= pending_items[0].inval;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (hold_request > 0 && accepted >= hold_request) begin
         stall_left <= 300;
         hold_request <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            rsp_gap_left = random_gap();
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result item, opcode %0d", rsp.opcode);
            end else begin
               e = expected_outcomes.pop_front();
               if (rsp.opcode !== e.opcode || rsp.out_kind !== e.kind
                   || rsp.out_value !== e.value || rsp.direction !== e.dir
                   || rsp.chooser_right !== e.chooser || rsp.depth_now !== e.depth
                   || rsp.status !== e.status) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected op %0d kind %0d val %h dir %0d ch %0d dep %0d st %0d",
                        e.opcode, e.kind, e.value, e.dir, e.chooser, e.depth, e.status);
                     $display("          got op %0d kind %0d val %h dir %0d ch %0d dep %0d st %0d",
                        rsp.opcode, rsp.out_kind, rsp.out_value, rsp.direction,
                        rsp.chooser_right, rsp.depth_now, rsp.status);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            rsp.ready <= 1'b0;
         end else if (rsp_gap_left > 0) begin
            rsp_gap_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic queue_op(logic [4:0] op, logic [31:0] v);
      pending_items.push_back(make_op(op, v[23:0], v));
   endtask

   // one random item: a push or read, a small roll after its two operands, or any opcode
   task automatic queue_random_item();
      int r;
      logic [4:0] op;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         case ($urandom_range(0, 3))
            0, 1: op = csm_pkg::OP_PUSH;
            2: op = csm_pkg::OP_READ_NUM;
            default: op = csm_pkg::OP_READ_CHAR;
         endcase
      end else if (r < 42) begin
         // small roll: depth then count
         queue_op(csm_pkg::OP_READ_NUM,
                  $urandom_range(0, 6) == 0 ? random_word() : $urandom_range(0, 6));
         queue_op(csm_pkg::OP_READ_NUM,
                  random_word() % 32'd64 - (($urandom_range(0, 1)) ? 32'd32 : 0));
         op = csm_pkg::OP_ROLL;
      end else op = 5'($urandom_range(0, 17));
      queue_op(op, random_word());
   endtask

   initial begin
      req.valid = 1'b0;
      req.from_hue = '0;
      req.from_lightness = '0;
      req.to_hue = '0;
      req.to_lightness = '0;
      req.codel_count = '0;
      req.in_value = '0;
      rsp.ready = 1'b0;
      model_count = 0;
      model_dir = '0;
      model_chooser = 1'b0;

      // directed: underflows, extremes, divide by zero, overflowing quotient, rolls
      queue_op(csm_pkg::OP_POP, 0);
      queue_op(csm_pkg::OP_ROLL, 0);
      queue_op(csm_pkg::OP_WRITE_NUM, 0);
      queue_op(csm_pkg::OP_PUSH, 32'h00ff_ffff);
      queue_op(csm_pkg::OP_ROLL, 0);
      queue_op(csm_pkg::OP_READ_NUM, 32'h8000_0000);
      queue_op(csm_pkg::OP_READ_NUM, 32'hffff_ffff);
      queue_op(csm_pkg::OP_DIV, 0);
      queue_op(csm_pkg::OP_READ_NUM, 32'h8000_0000);
      queue_op(csm_pkg::OP_READ_NUM, 32'hffff_ffff);
      queue_op(csm_pkg::OP_MOD, 0);
      queue_op(csm_pkg::OP_READ_NUM, 0);
      queue_op(csm_pkg::OP_DIV, 0);
      queue_op(csm_pkg::OP_MOD, 0);
      queue_op(csm_pkg::OP_READ_CHAR, 32'h7fff_ffff);
      queue_op(csm_pkg::OP_READ_NUM, 2);
      queue_op(csm_pkg::OP_READ_NUM, 32'hffff_fffd);
      queue_op(csm_pkg::OP_ROLL, 0);
      for (int op = 0; op <= 17; op++) queue_op(5'(op), random_word());
      // pause until drained
      drain_request = 0;
      for (int i = 0; i < 170; i++) begin
         queue_random_item();
         if (i == 100) drain_request = pending_items.size();
      end
      // fill the stack beyond its depth, then drain a little
      for (int i = 0; i < DEPTH + 4; i++) queue_op(csm_pkg::OP_DUP, 0);
      queue_op(csm_pkg::OP_PUSH, 5);
      queue_op(csm_pkg::OP_READ_NUM, 3);
      queue_op(csm_pkg::OP_READ_NUM, 1);
      queue_op(csm_pkg::OP_ROLL, 0);
      for (int i = 0; i < 40; i++) queue_random_item();
      hold_request = 100;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || expected_outcomes.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/csm_pkg.sv
rtl/core/csm_if.sv
rtl/core/csm_divider.sv
rtl/core/color_stack_machine_executor_unit.sv
rtl/core/csm_checker.sv
tb/sv/color_stack_machine_executor_unit_tb.sv
